/* rtl/core/turing_machine_stepper_core_assert.svh */
// Assertion macros for the Turing machine stepper core.
`ifndef TURING_MACHINE_STEPPER_CORE_ASSERT_SVH
`define TURING_MACHINE_STEPPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TMS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TMS_ASSERT(lbl, prop)
`define TMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/tms_pkg.sv */
// Types and constants shared by the Turing machine stepper core.
`timescale 1ns / 1ps

package tms_pkg;

    localparam logic [1:0] REQ_RULE  = 2'd0;
    localparam logic [1:0] REQ_TAPE  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;
    localparam logic [1:0] REQ_STEP  = 2'd3;

    localparam logic [1:0] DIR_STAY  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    localparam logic [2:0] STS_ACK         = 3'd0;
    localparam logic [2:0] STS_STEPPED     = 3'd1;
    localparam logic [2:0] STS_HALTED      = 3'd2;
    localparam logic [2:0] STS_NO_RULE     = 3'd3;
    localparam logic [2:0] STS_OFF_TAPE    = 3'd4;
    localparam logic [2:0] STS_NOT_RUNNING = 3'd5;

    localparam logic [7:0] BLANK_SYMBOL = 8'h20;
    localparam logic [7:0] HALT_RESET   = 8'h21;

    localparam logic CFG_RULE_COUNT = 1'b0;
    localparam logic CFG_HALT_STATE = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] addr;
        logic [7:0] cur_state;
        logic [7:0] cur_symbol;
        logic       match_any;
        logic [7:0] next_symbol;
        logic [7:0] next_state;
        logic [1:0] direction;
    } tms_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] rule_line;
        logic [6:0] head_pos;
        logic [7:0] state_code;
        logic [7:0] written_symbol;
    } tms_rsp_t;

    typedef struct packed {
        logic [7:0] match_state;
        logic [7:0] match_symbol;
        logic       any;
        logic [7:0] write_symbol;
        logic [7:0] new_state;
        logic [1:0] move;
    } tms_rule_t;

endpackage

/* rtl/core/tms_rule_mem.sv */
// Rule table: simple dual-port synchronous memory with a registered read.
`timescale 1ns / 1ps

module tms_rule_mem
    import tms_pkg::*;
#(
    parameter int RULES = 64,
    localparam int AW = (RULES > 1) ? $clog2(RULES) : 1
)
(
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  tms_rule_t       wr_data,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    output tms_rule_t       rd_data
);

    tms_rule_t mem [RULES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/tms_tape_mem.sv */
// Tape memory with a blanking sweep after reset and a registered read.
`timescale 1ns / 1ps

module tms_tape_mem
    import tms_pkg::*;
#(
    parameter int TAPE_CELLS = 128,
    localparam int AW = $clog2(TAPE_CELLS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    output logic          ready
);

    logic [7:0]    mem [TAPE_CELLS];
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [AW-1:0] clr_idx_reg;
    logic [AW-1:0] clr_idx_next;
    logic          we;
    logic [AW-1:0] wa;
    logic [7:0]    wd;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == AW'(TAPE_CELLS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    assign we    = clr_busy_reg | wr_en;
    assign wa    = clr_busy_reg ? clr_idx_reg : wr_addr;
    assign wd    = clr_busy_reg ? BLANK_SYMBOL : wr_data;
    assign ready = ~clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/turing_machine_stepper_core.sv */
// Turing machine stepper core: request control, rule scan, config registers.
// Loads, start and steps while stopped go straight from acceptance to the response state.
// A step scans the rule entries in order, at most RULES of them (bounded also by
// the rule count): the scan reads one rule entry per cycle from the rule memory port.
// One request is in flight; the next is taken once the response is registered.
// After reset the tape is blanked one cell per cycle over all TAPE_CELLS cells;
// requests stall meanwhile, configuration writes are taken.
`timescale 1ns / 1ps
`include "turing_machine_stepper_core_assert.svh"

module turing_machine_stepper_core
    import tms_pkg::*;
#(
    parameter int RULES      = 64,
    parameter int TAPE_CELLS = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  tms_req_t    req_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output tms_rsp_t    rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RAW = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int CW  = $clog2(RULES + 1);
    localparam int TAW = $clog2(TAPE_CELLS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0]     st_reg;
    logic [1:0]     st_next;
    logic [6:0]     rule_count_reg;
    logic [7:0]     halt_state_reg;
    logic [TAW-1:0] head_reg;
    logic [TAW-1:0] head_next;
    logic [7:0]     mstate_reg;
    logic [7:0]     mstate_next;
    logic           running_reg;
    logic           running_next;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  idx_next;
    logic [CW-1:0]  limit_reg;
    logic [CW-1:0]  limit_next;
    tms_rsp_t       res_reg;
    tms_rsp_t       res_next;
    logic           rsp_valid_reg;
    tms_rsp_t       rsp_data_reg;

    logic           cfg_wr;
    logic           accept;
    logic           rsp_free;
    logic [CW-1:0]  limit_now;
    logic [TAW-1:0] start_head;

    logic           rule_wr_en;
    logic           rule_rd_en;
    logic [RAW-1:0] rule_rd_addr;
    tms_rule_t      rule_wr_data;
    tms_rule_t      rule_rd_data;
    logic           tape_wr_en;
    logic [TAW-1:0] tape_wr_addr;
    logic [7:0]     tape_wr_data;
    logic           tape_rd_en;
    logic [7:0]     tape_rd_data;
    logic           tape_ready;

    logic           hit;
    logic           off;
    logic [TAW-1:0] moved_head;

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            CFG_RULE_COUNT: prdata = {25'd0, rule_count_reg};
            CFG_HALT_STATE: prdata = {24'd0, halt_state_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_count_reg <= '0;
            halt_state_reg <= HALT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == CFG_RULE_COUNT)
            begin
                rule_count_reg <= pwdata[6:0];
            end
            else
            begin
                halt_state_reg <= pwdata[7:0];
            end
        end
    end

    assign req_stall = ~((st_reg == S_IDLE) & tape_ready);
    assign accept    = req_valid & ~req_stall;
    assign rsp_free  = ~rsp_valid_reg | ~rsp_stall;

    assign limit_now  = (32'(rule_count_reg) < RULES) ? CW'(rule_count_reg) : CW'(RULES);
    assign start_head = (32'(req_data.addr) < TAPE_CELLS) ? TAW'(req_data.addr)
                                                          : TAW'(TAPE_CELLS - 1);

    assign rule_wr_data.match_state  = req_data.cur_state;
    assign rule_wr_data.match_symbol = req_data.cur_symbol;
    assign rule_wr_data.any          = req_data.match_any;
    assign rule_wr_data.write_symbol = req_data.next_symbol;
    assign rule_wr_data.new_state    = req_data.next_state;
    assign rule_wr_data.move         = req_data.direction;

    assign rule_wr_en = accept & (req_data.req_type == REQ_RULE)
                        & (32'(req_data.addr) < RULES);

    assign hit = (st_reg == S_SCAN)
                 & (rule_rd_data.match_state == mstate_reg)
                 & (rule_rd_data.any | (rule_rd_data.match_symbol == tape_rd_data));

    always_comb
    begin
        off        = 1'b0;
        moved_head = head_reg;
        case (rule_rd_data.move)
            DIR_LEFT:
            begin
                if (head_reg == '0)
                begin
                    off = 1'b1;
                end
                else
                begin
                    moved_head = head_reg - 1'b1;
                end
            end
            DIR_RIGHT:
            begin
                if (head_reg == TAW'(TAPE_CELLS - 1))
                begin
                    off = 1'b1;
                end
                else
                begin
                    moved_head = head_reg + 1'b1;
                end
            end
            default:
            begin
                moved_head = head_reg;
            end
        endcase
    end

    always_comb
    begin
        st_next      = st_reg;
        head_next    = head_reg;
        mstate_next  = mstate_reg;
        running_next = running_reg;
        idx_next     = idx_reg;
        limit_next   = limit_reg;
        res_next     = res_reg;
        rule_rd_en   = 1'b0;
        rule_rd_addr = '0;
        tape_wr_en   = 1'b0;
        tape_wr_addr = TAW'(req_data.addr);
        tape_wr_data = req_data.cur_symbol;
        tape_rd_en   = 1'b0;

        unique case (st_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '{status: STS_ACK, rule_line: '0,
                                 head_pos: 7'(head_reg), state_code: mstate_reg,
                                 written_symbol: '0};
                    st_next  = S_RESP;
                    case (req_data.req_type)
                        REQ_TAPE:
                        begin
                            tape_wr_en = (32'(req_data.addr) < TAPE_CELLS);
                        end
                        REQ_START:
                        begin
                            head_next           = start_head;
                            mstate_next         = req_data.cur_state;
                            running_next        = 1'b1;
                            res_next.head_pos   = 7'(start_head);
                            res_next.state_code = req_data.cur_state;
                        end
                        REQ_STEP:
                        begin
                            if (!running_reg)
                            begin
                                res_next.status = STS_NOT_RUNNING;
                            end
                            else if (limit_now == '0)
                            begin
                                res_next.status = STS_NO_RULE;
                                running_next    = 1'b0;
                            end
                            else
                            begin
                                rule_rd_en   = 1'b1;
                                rule_rd_addr = '0;
                                tape_rd_en   = 1'b1;
                                idx_next     = '0;
                                limit_next   = limit_now;
                                st_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    tape_wr_en   = 1'b1;
                    tape_wr_addr = head_reg;
                    tape_wr_data = rule_rd_data.write_symbol;
                    head_next    = moved_head;
                    mstate_next  = rule_rd_data.new_state;
                    res_next     = '{status: STS_STEPPED, rule_line: 6'(idx_reg),
                                     head_pos: 7'(moved_head),
                                     state_code: rule_rd_data.new_state,
                                     written_symbol: rule_rd_data.write_symbol};
                    if (off)
                    begin
                        res_next.status = STS_OFF_TAPE;
                        running_next    = 1'b0;
                    end
                    else if (rule_rd_data.new_state == halt_state_reg)
                    begin
                        res_next.status = STS_HALTED;
                        running_next    = 1'b0;
                    end
                    st_next = S_RESP;
                end
                else if (idx_reg + 1'b1 < limit_reg)
                begin
                    idx_next     = idx_reg + 1'b1;
                    rule_rd_en   = 1'b1;
                    rule_rd_addr = RAW'(idx_reg + 1'b1);
                end
                else
                begin
                    running_next = 1'b0;
                    res_next     = '{status: STS_NO_RULE, rule_line: '0,
                                     head_pos: 7'(head_reg), state_code: mstate_reg,
                                     written_symbol: '0};
                    st_next      = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            head_reg      <= TAW'(TAPE_CELLS / 2);
            mstate_reg    <= '0;
            running_reg   <= 1'b0;
            idx_reg       <= '0;
            limit_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            head_reg    <= head_next;
            mstate_reg  <= mstate_next;
            running_reg <= running_next;
            idx_reg     <= idx_next;
            limit_reg   <= limit_next;
            if (st_reg == S_RESP && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (st_reg == S_RESP && rsp_free)
        begin
            rsp_data_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    tms_rule_mem #(
        .RULES (RULES)
    ) u_rule_mem (
        .clk     (clk),
        .wr_en   (rule_wr_en),
        .wr_addr (RAW'(req_data.addr)),
        .wr_data (rule_wr_data),
        .rd_en   (rule_rd_en),
        .rd_addr (rule_rd_addr),
        .rd_data (rule_rd_data)
    );

    tms_tape_mem #(
        .TAPE_CELLS (TAPE_CELLS)
    ) u_tape_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tape_wr_en),
        .wr_addr (tape_wr_addr),
        .wr_data (tape_wr_data),
        .rd_en   (tape_rd_en),
        .rd_addr (head_reg),
        .rd_data (tape_rd_data),
        .ready   (tape_ready)
    );

    `TMS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, st_reg != S_IDLE)
    `TMS_ASSERT(a_no_req_while_clear, !tape_ready |-> req_stall)
    `TMS_ASSERT(a_scan_in_limit, st_reg == S_SCAN |-> idx_reg < limit_reg)
    `TMS_ASSERT(a_rsp_from_resp, $rose(rsp_valid) |-> $past(st_reg) == S_RESP)
    `TMS_ASSERT(a_head_on_tape, 32'(head_reg) < TAPE_CELLS)

endmodule
